[rtl/qzy_pkg.sv]
`timescale 1ns / 1ps

package qzy_pkg;

    localparam int Z_W = 34;
    localparam int ATAN_LEN = 24;
    localparam int ANG_W = 17;

    localparam logic signed [ANG_W-1:0] ANG_PI_Q13 = 17'sd25736;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI_Q13 = 17'sd51472;
    localparam logic signed [Z_W-1:0] ANG_HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [Z_W-1:0] ROUND_HALF_Q30 = 34'sd65536;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MUL,
        FR_FORM,
        FR_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ITER,
        BK_ROUND,
        BK_FINISH
    } back_state_t;

    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_RIGHT,
        CLS_LEFT_UP,
        CLS_LEFT_DOWN
    } yaw_class_t;

    function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0: v = 32'h3243F6A8;
                5'd1: v = 32'h1DAC6705;
                5'd2: v = 32'h0FADBAFC;
                5'd3: v = 32'h07F56EA6;
                5'd4: v = 32'h03FEAB76;
                5'd5: v = 32'h01FFD55B;
                5'd6: v = 32'h00FFFAAA;
                5'd7: v = 32'h007FFF55;
                5'd8: v = 32'h003FFFEA;
                5'd9: v = 32'h001FFFFD;
                5'd10: v = 32'h000FFFFF;
                5'd11: v = 32'h0007FFFF;
                5'd12: v = 32'h0003FFFF;
                5'd13: v = 32'h0001FFFF;
                5'd14: v = 32'h0000FFFF;
                5'd15: v = 32'h00007FFF;
                5'd16: v = 32'h00003FFF;
                5'd17: v = 32'h00001FFF;
                5'd18: v = 32'h00000FFF;
                5'd19: v = 32'h000007FF;
                5'd20: v = 32'h000003FF;
                5'd21: v = 32'h000001FF;
                5'd22: v = 32'h000000FF;
                5'd23: v = 32'h0000007F;
                default: v = 32'h00000000;
            endcase
            atan_q30 = {2'b00, v};
        end
    endfunction

endpackage

[rtl/qzy_front.sv]
`timescale 1ns / 1ps

module qzy_front #(
    parameter int QUAT_FRACTION_BITS = 14,
    parameter int XY_W = 36
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [63:0]         s_tdata,
    output logic                q_valid,
    input  logic                q_ready,
    output logic [2*XY_W+1:0]   q_data
);

    localparam logic signed [XY_W-1:0] ONE_VAL =
        {{(XY_W-1){1'b0}}, 1'b1} << (2 * QUAT_FRACTION_BITS);

    qzy_pkg::front_state_t state_reg, state_next;

    logic signed [15:0] qi_reg, qj_reg, qk_reg, qr_reg;
    logic signed [15:0] qi_next, qj_next, qk_next, qr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic signed [31:0] prod_reg, prod_next;
    logic signed [32:0] sum_y_reg, sum_y_next, sum_x_reg, sum_x_next;
    logic signed [XY_W-1:0] x_reg, x_next, y_reg, y_next;

    logic accept, mul_en, form_en;
    logic signed [15:0] mul_a, mul_b;
    logic signed [32:0] prod_ext;
    logic signed [XY_W-1:0] x_rot, y_rot;
    qzy_pkg::yaw_class_t cls;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qzy_pkg::FR_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = qzy_pkg::FR_MUL;
                end
            end
            qzy_pkg::FR_MUL:
            begin
                if (cnt_reg == 3'd4)
                begin
                    state_next = qzy_pkg::FR_FORM;
                end
            end
            qzy_pkg::FR_FORM:
            begin
                state_next = qzy_pkg::FR_PUSH;
            end
            qzy_pkg::FR_PUSH:
            begin
                if (q_ready)
                begin
                    state_next = qzy_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = qzy_pkg::FR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        mul_en = 1'b0;
        form_en = 1'b0;
        q_valid = 1'b0;
        case (state_reg)
            qzy_pkg::FR_IDLE: s_tready = 1'b1;
            qzy_pkg::FR_MUL: mul_en = 1'b1;
            qzy_pkg::FR_FORM: form_en = 1'b1;
            qzy_pkg::FR_PUSH: q_valid = 1'b1;
            default: s_tready = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:
            begin
                mul_a = qi_reg;
                mul_b = qj_reg;
            end
            2'd1:
            begin
                mul_a = qk_reg;
                mul_b = qr_reg;
            end
            2'd2:
            begin
                mul_a = qj_reg;
                mul_b = qj_reg;
            end
            default:
            begin
                mul_a = qk_reg;
                mul_b = qk_reg;
            end
        endcase
    end

    assign prod_ext = {prod_reg[31], prod_reg};

    always_comb
    begin
        qi_next = qi_reg;
        qj_next = qj_reg;
        qk_next = qk_reg;
        qr_next = qr_reg;
        cnt_next = cnt_reg;
        prod_next = prod_reg;
        sum_y_next = sum_y_reg;
        sum_x_next = sum_x_reg;
        x_next = x_reg;
        y_next = y_reg;
        if (accept)
        begin
            qi_next = s_tdata[15:0];
            qj_next = s_tdata[31:16];
            qk_next = s_tdata[47:32];
            qr_next = s_tdata[63:48];
            cnt_next = 3'd0;
        end
        if (mul_en)
        begin
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg != 3'd4)
            begin
                prod_next = 32'(mul_a) * 32'(mul_b);
            end
            case (cnt_reg)
                3'd1: sum_y_next = prod_ext;
                3'd2: sum_y_next = sum_y_reg + prod_ext;
                3'd3: sum_x_next = prod_ext;
                3'd4: sum_x_next = sum_x_reg + prod_ext;
                default: sum_x_next = sum_x_reg;
            endcase
        end
        if (form_en)
        begin
            y_next = {{(XY_W-34){sum_y_reg[32]}}, sum_y_reg, 1'b0};
            x_next = ONE_VAL - {{(XY_W-34){sum_x_reg[32]}}, sum_x_reg, 1'b0};
        end
    end

    // turn left half-plane vectors into the right half-plane
    always_comb
    begin
        x_rot = x_reg;
        y_rot = y_reg;
        if (x_reg == '0 && y_reg == '0)
        begin
            cls = qzy_pkg::CLS_ZERO;
        end
        else if (x_reg[XY_W-1])
        begin
            if (!y_reg[XY_W-1])
            begin
                cls = qzy_pkg::CLS_LEFT_UP;
                x_rot = y_reg;
                y_rot = -x_reg;
            end
            else
            begin
                cls = qzy_pkg::CLS_LEFT_DOWN;
                x_rot = -y_reg;
                y_rot = x_reg;
            end
        end
        else
        begin
            cls = qzy_pkg::CLS_RIGHT;
        end
    end

    assign q_data = {cls, y_rot, x_rot};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qzy_pkg::FR_IDLE;
            cnt_reg <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qi_reg <= qi_next;
        qj_reg <= qj_next;
        qk_reg <= qk_next;
        qr_reg <= qr_next;
        prod_reg <= prod_next;
        sum_y_reg <= sum_y_next;
        sum_x_reg <= sum_x_next;
        x_reg <= x_next;
        y_reg <= y_next;
    end

endmodule

[rtl/qzy_fifo.sv]
`timescale 1ns / 1ps

module qzy_fifo #(
    parameter int WIDTH = 74
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/qzy_back.sv]
`timescale 1ns / 1ps

module qzy_back #(
    parameter int CORDIC_STEPS = 16,
    parameter int XY_W = 36
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  logic [2*XY_W+1:0] q_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,
    output logic              m_tuser,
    output logic              offset_captured
);

    localparam int STEPS_EFF =
        (CORDIC_STEPS < qzy_pkg::ATAN_LEN) ? CORDIC_STEPS : qzy_pkg::ATAN_LEN;
    localparam int CNT_W = $clog2(STEPS_EFF);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS_EFF - 1);
    localparam int Z_W = qzy_pkg::Z_W;
    localparam int ANG_W = qzy_pkg::ANG_W;

    qzy_pkg::back_state_t state_reg, state_next;

    logic signed [XY_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0] z_reg, z_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic signed [15:0] raw_reg, raw_next;
    logic signed [15:0] ref_reg, ref_next;
    logic captured_reg, captured_next;
    logic out_valid_reg, out_valid_next;
    logic signed [15:0] yaw_reg, yaw_next;
    logic is_ref_reg, is_ref_next;

    logic load_en, iter_en, round_en, finish_en, out_free;
    qzy_pkg::yaw_class_t cls_in;
    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0] atan_val, z_round;
    logic signed [ANG_W-1:0] r_full, diff;

    assign cls_in = qzy_pkg::yaw_class_t'(q_data[2*XY_W +: 2]);
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qzy_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (cls_in == qzy_pkg::CLS_ZERO) ? qzy_pkg::BK_ROUND
                                                                : qzy_pkg::BK_ITER;
                end
            end
            qzy_pkg::BK_ITER:
            begin
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = qzy_pkg::BK_ROUND;
                end
            end
            qzy_pkg::BK_ROUND:
            begin
                state_next = qzy_pkg::BK_FINISH;
            end
            qzy_pkg::BK_FINISH:
            begin
                if (out_free)
                begin
                    state_next = qzy_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = qzy_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_ready = 1'b0;
        iter_en = 1'b0;
        round_en = 1'b0;
        finish_en = 1'b0;
        case (state_reg)
            qzy_pkg::BK_IDLE: q_ready = 1'b1;
            qzy_pkg::BK_ITER: iter_en = 1'b1;
            qzy_pkg::BK_ROUND: round_en = 1'b1;
            qzy_pkg::BK_FINISH: finish_en = out_free;
            default: q_ready = 1'b0;
        endcase
    end

    assign load_en = q_valid && q_ready;

    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;
    assign atan_val = qzy_pkg::atan_q30(5'(cnt_reg));
    assign z_round = z_reg + qzy_pkg::ROUND_HALF_Q30;
    assign r_full = z_round[Z_W-1:Z_W-ANG_W];
    assign diff = {raw_reg[15], raw_reg} - {ref_reg[15], ref_reg};

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        cnt_next = cnt_reg;
        raw_next = raw_reg;
        ref_next = ref_reg;
        captured_next = captured_reg;
        yaw_next = yaw_reg;
        is_ref_next = is_ref_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_en)
        begin
            x_next = q_data[XY_W-1:0];
            y_next = q_data[2*XY_W-1:XY_W];
            cnt_next = '0;
            case (cls_in)
                qzy_pkg::CLS_LEFT_UP: z_next = qzy_pkg::ANG_HALF_PI_Q30;
                qzy_pkg::CLS_LEFT_DOWN: z_next = -qzy_pkg::ANG_HALF_PI_Q30;
                default: z_next = '0;
            endcase
        end
        if (iter_en)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (!y_reg[XY_W-1])
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_val;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_val;
            end
        end
        if (round_en)
        begin
            if (r_full > qzy_pkg::ANG_PI_Q13)
            begin
                raw_next = qzy_pkg::ANG_PI_Q13[15:0];
            end
            else if (r_full < -qzy_pkg::ANG_PI_Q13)
            begin
                raw_next = -qzy_pkg::ANG_PI_Q13[15:0];
            end
            else
            begin
                raw_next = r_full[15:0];
            end
        end
        if (finish_en)
        begin
            out_valid_next = 1'b1;
            if (!captured_reg)
            begin
                ref_next = raw_reg;
                captured_next = 1'b1;
                yaw_next = '0;
                is_ref_next = 1'b1;
            end
            else
            begin
                is_ref_next = 1'b0;
                if (diff > qzy_pkg::ANG_PI_Q13)
                begin
                    yaw_next = 16'(diff - qzy_pkg::ANG_TWO_PI_Q13);
                end
                else if (diff < -qzy_pkg::ANG_PI_Q13)
                begin
                    yaw_next = 16'(diff + qzy_pkg::ANG_TWO_PI_Q13);
                end
                else
                begin
                    yaw_next = diff[15:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qzy_pkg::BK_IDLE;
            cnt_reg <= '0;
            captured_reg <= 1'b0;
            ref_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            captured_reg <= captured_next;
            ref_reg <= ref_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        raw_reg <= raw_next;
        yaw_reg <= yaw_next;
        is_ref_reg <= is_ref_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = yaw_reg;
    assign m_tuser = is_ref_reg;
    assign offset_captured = captured_reg;

endmodule

[rtl/quaternion_to_zeroed_yaw.sv]
`timescale 1ns / 1ps

// zeroed yaw heading from a game-rotation quaternion. each input transaction carries one
// quaternion (i, j, k, real) in signed fixed point; each output transaction carries the yaw in
// signed q2.13 radians wrapped to plus or minus pi, with tuser set on the first sample after
// reset, which becomes the zero heading and reads as 0. the front end forms the two atan2
// arguments with one shared 16x16 multiplier and hands them through a two-entry queue to the
// back end, which runs a cordic vectoring loop one iteration per cycle. the back end sets the
// rate (a zero vector skips the loop, so then the front end sets the pace).

module quaternion_to_zeroed_yaw #(
    parameter int CORDIC_STEPS = 16,
    parameter int QUAT_FRACTION_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_i, quat_j, quat_k, quat_real
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // yaw_angle
    output logic        m_tuser    // is_reference
);

    localparam int XY_W = ((2 * QUAT_FRACTION_BITS > 32) ? 2 * QUAT_FRACTION_BITS : 32) + 4;
    localparam int Q_W = 2 * XY_W + 2;

    logic q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
    logic [Q_W-1:0] q_push_data, q_pop_data;
    logic offset_captured;

    qzy_front #(
        .QUAT_FRACTION_BITS(QUAT_FRACTION_BITS),
        .XY_W(XY_W)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .q_valid(q_push_valid),
        .q_ready(q_push_ready),
        .q_data(q_push_data)
    );

    qzy_fifo #(
        .WIDTH(Q_W)
    ) u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push_valid(q_push_valid),
        .push_ready(q_push_ready),
        .push_data(q_push_data),
        .pop_valid(q_pop_valid),
        .pop_ready(q_pop_ready),
        .pop_data(q_pop_data)
    );

    qzy_back #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .XY_W(XY_W)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_valid(q_pop_valid),
        .q_ready(q_pop_ready),
        .q_data(q_pop_data),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .offset_captured(offset_captured)
    );

    a_ref_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 16'd0)
        else $error("reference transaction with nonzero yaw");

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata) <= 16'sd25736 && $signed(m_tdata) >= -16'sd25736))
        else $error("yaw outside plus or minus pi");

    a_ref_needs_capture: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> offset_captured)
        else $error("reference flag without captured offset");

    a_capture_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        offset_captured |=> offset_captured)
        else $error("captured offset lost");

    a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
        q_push_valid && !q_push_ready |=> q_push_valid && $stable(q_push_data))
        else $error("front end dropped a stalled job");

endmodule
